// ===== hw/rtl/jpp_pkg.sv =====
`timescale 1ns / 1ps

package jpp_pkg;

  localparam int DEPTH_W = 5;
  localparam int SP_W    = DEPTH_W + 1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // lexer state kept between bytes
  typedef struct packed {
    logic               inside_string;
    logic               escape_pending;
    logic [DEPTH_W-1:0] nest_depth;
  } jpp_state_t;

  // output run for one input byte: byte0, byte1, nsp spaces, byte2
  typedef struct packed {
    logic            has0;
    logic [7:0]      byte0;
    logic            has1;
    logic [7:0]      byte1;
    logic [SP_W-1:0] nsp;
    logic            has2;
    logic [7:0]      byte2;
  } jpp_plan_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_B0,
    SEQ_B1,
    SEQ_SP,
    SEQ_B2
  } seq_phase_t;

endpackage

// ===== hw/rtl/jpp_decode.sv =====
`timescale 1ns / 1ps

module jpp_decode import jpp_pkg::*; #(
  parameter int MAX_DEPTH = 31
) (
  input  logic [7:0] in_byte,
  input  jpp_state_t cur,
  output jpp_state_t nxt,
  output jpp_plan_t  plan
);

  logic [DEPTH_W-1:0] deeper;
  logic [DEPTH_W-1:0] shallower;

  assign deeper    = (cur.nest_depth < DEPTH_W'(MAX_DEPTH)) ?
                     cur.nest_depth + DEPTH_W'(1) : cur.nest_depth;
  assign shallower = (cur.nest_depth != '0) ?
                     cur.nest_depth - DEPTH_W'(1) : cur.nest_depth;

  always_comb begin
    nxt  = cur;
    plan = '0;
    if (cur.inside_string) begin
      plan.has0  = 1'b1;
      plan.byte0 = in_byte;
      if (cur.escape_pending) begin
        nxt.escape_pending = 1'b0;
      end else if (in_byte == CH_BSLASH) begin
        nxt.escape_pending = 1'b1;
      end else if (in_byte == CH_QUOTE) begin
        nxt.inside_string = 1'b0;
      end
    end else begin
      case (in_byte) inside
        CH_QUOTE: begin
          nxt.inside_string = 1'b1;
          plan.has0         = 1'b1;
          plan.byte0        = in_byte;
        end
        CH_LBRACE, CH_LBRACK: begin
          nxt.nest_depth = deeper;
          plan.has0      = 1'b1;
          plan.byte0     = in_byte;
          plan.has1      = 1'b1;
          plan.byte1     = CH_LF;
          plan.nsp       = {deeper, 1'b0};
        end
        CH_RBRACE, CH_RBRACK: begin
          nxt.nest_depth = shallower;
          plan.has1      = 1'b1;
          plan.byte1     = CH_LF;
          plan.nsp       = {shallower, 1'b0};
          plan.has2      = 1'b1;
          plan.byte2     = in_byte;
        end
        CH_COMMA: begin
          plan.has0  = 1'b1;
          plan.byte0 = in_byte;
          plan.has1  = 1'b1;
          plan.byte1 = CH_LF;
          plan.nsp   = {cur.nest_depth, 1'b0};
        end
        CH_COLON: begin
          plan.has0  = 1'b1;
          plan.byte0 = CH_COLON;
          plan.has1  = 1'b1;
          plan.byte1 = CH_SPACE;
        end
        CH_LF, CH_CR, CH_TAB: begin
          plan = '0;
        end
        default: begin
          plan.has0  = 1'b1;
          plan.byte0 = in_byte;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/jpp_seq.sv =====
`timescale 1ns / 1ps

module jpp_seq import jpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  jpp_plan_t  plan,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  seq_phase_t      phase_r, phase_nxt;
  jpp_plan_t       plan_r, plan_nxt;
  logic [SP_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic            adv;

  // first present phase strictly after cur (cur == SEQ_IDLE means before byte0)
  function automatic seq_phase_t next_phase(input jpp_plan_t p, input seq_phase_t cur);
    logic chk0, chk1, chk_sp, chk2;
    seq_phase_t nx;
    chk0   = (cur == SEQ_IDLE);
    chk1   = chk0 || (cur == SEQ_B0);
    chk_sp = chk1 || (cur == SEQ_B1);
    chk2   = chk_sp || (cur == SEQ_SP);
    if (chk0 && p.has0)                nx = SEQ_B0;
    else if (chk1 && p.has1)           nx = SEQ_B1;
    else if (chk_sp && (p.nsp != '0))  nx = SEQ_SP;
    else if (chk2 && p.has2)           nx = SEQ_B2;
    else                               nx = SEQ_IDLE;
    return nx;
  endfunction

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    plan_r     <= plan_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    plan_nxt      = plan_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (phase_r)
      SEQ_IDLE: begin
        if (load) begin
          plan_nxt  = plan;
          cnt_nxt   = plan.nsp;
          phase_nxt = next_phase(plan, SEQ_IDLE);
        end
      end
      SEQ_B0: begin
        if (adv) begin
          phase_nxt    = next_phase(plan_r, SEQ_B0);
          out_byte_nxt = plan_r.byte0;
        end
      end
      SEQ_B1: begin
        if (adv) begin
          phase_nxt    = next_phase(plan_r, SEQ_B1);
          out_byte_nxt = plan_r.byte1;
        end
      end
      SEQ_SP: begin
        if (adv) begin
          cnt_nxt      = cnt_r - SP_W'(1);
          out_byte_nxt = CH_SPACE;
          if (cnt_r == SP_W'(1)) begin
            phase_nxt = next_phase(plan_r, SEQ_SP);
          end
        end
      end
      SEQ_B2: begin
        if (adv) begin
          phase_nxt    = SEQ_IDLE;
          out_byte_nxt = plan_r.byte2;
        end
      end
      default: begin
        phase_nxt = SEQ_IDLE;
      end
    endcase
    if ((phase_r != SEQ_IDLE) && adv) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (phase_nxt == SEQ_IDLE);
    end
  end

  assign busy         = (phase_r != SEQ_IDLE);
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

endmodule

// ===== hw/rtl/json_pretty_printer.sv =====
// first output: the sequencer registers the plan, then the output register the byte
// throughput: a byte yielding n output beats holds the input until its run ends, one
//   output beat per cycle while out_ready is high; indentation runs of up to 2*MAX_DEPTH
//   spaces come from the sequencer's space down-counter; a dropped byte leaves it idle
// reset: synchronous active-low rst_n clears lexer state, sequencer and output valid
`timescale 1ns / 1ps

module json_pretty_printer import jpp_pkg::*; #(
  parameter int MAX_DEPTH = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  // input beats: one byte of compact text
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_doc_end,
  // output beats: one byte of formatted text
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  jpp_state_t state_r, state_nxt;
  jpp_state_t dec_state;
  jpp_plan_t  dec_plan;
  logic       in_accept;
  logic       seq_busy;

  // input is taken whenever the sequencer has no run in progress; the
  // output register lets a new byte in while the last beat still waits
  assign in_ready  = !seq_busy;
  assign in_accept = in_valid && in_ready;

  // classify the byte against the current lexer state
  jpp_decode #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_decode (
    .in_byte (in_byte),
    .cur     (state_r),
    .nxt     (dec_state),
    .plan    (dec_plan)
  );

  // state advances at accept; end of document returns it to reset values
  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      state_nxt = in_doc_end ? jpp_state_t'('0) : dec_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer walks the run: leading bytes, space counter, trailing byte
  jpp_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_accept),
    .plan         (dec_plan),
    .busy         (seq_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import jpp_pkg::*;

  localparam int MAX_NEST     = 31;
  localparam int RANDOM_ITEMS = 310;
  localparam int DEEP_OPENERS = MAX_NEST + 2;   // runs past the depth ceiling
  localparam int LONG_HOLD    = 300;            // receiver back-pressure stretch
  localparam int TAIL_CYCLES  = 20;             // pipeline drain after last beat
  localparam int STALL_LIMIT  = 2000;           // cycles with no beat on either side

  // one byte of compact text waiting to be offered, with its pre-offer gap
  typedef struct {
    logic [7:0]  data;
    logic        doc_end;
    int unsigned gap;
  } text_beat_t;

  // one byte of formatted text the block must produce
  typedef struct {
    logic [7:0] ch;
    logic       run_end;
  } fmt_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_doc_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  text_beat_t  text_queue[$];
  fmt_beat_t   fmt_expected[$];

  // formatter state mirrored from the compact text accepted so far
  logic        lex_in_string = 1'b0;
  logic        lex_escape    = 1'b0;
  logic [4:0]  lex_depth     = '0;

  int unsigned errors      = 0;
  int unsigned beats_seen  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;

  json_pretty_printer #(
    .MAX_DEPTH(MAX_NEST)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_doc_end  (in_doc_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_run_last(out_run_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // formatter prediction: one accepted text byte -> its run of formatted beats
  // ---------------------------------------------------------------------------
  task automatic emit_fmt(input logic [7:0] ch, inout int n);
    fmt_expected.push_back('{ch: ch, run_end: 1'b0});
    n++;
  endtask

  task automatic emit_indent(inout int n);
    for (int lvl = 0; lvl < int'(lex_depth); lvl++) begin
      emit_fmt(CH_SPACE, n);
      emit_fmt(CH_SPACE, n);
    end
  endtask

  task automatic format_byte(input logic [7:0] c, input logic last_of_doc);
    int n;
    n = 0;
    if (lex_in_string) begin
      // string body passes through; backslash shields the next byte
      emit_fmt(c, n);
      if (lex_escape)
        lex_escape = 1'b0;
      else if (c == CH_BSLASH)
        lex_escape = 1'b1;
      else if (c == CH_QUOTE)
        lex_in_string = 1'b0;
    end else begin
      case (c)
        CH_QUOTE: begin
          lex_in_string = 1'b1;
          emit_fmt(c, n);
        end
        CH_LBRACE, CH_LBRACK: begin
          emit_fmt(c, n);
          emit_fmt(CH_LF, n);
          // depth saturates at the ceiling, indent still uses the ceiling
          if (int'(lex_depth) < MAX_NEST)
            lex_depth = lex_depth + 5'd1;
          emit_indent(n);
        end
        CH_RBRACE, CH_RBRACK: begin
          emit_fmt(CH_LF, n);
          // a stray closer at top level stays at depth zero
          if (lex_depth != 0)
            lex_depth = lex_depth - 5'd1;
          emit_indent(n);
          emit_fmt(c, n);
        end
        CH_COMMA: begin
          emit_fmt(c, n);
          emit_fmt(CH_LF, n);
          emit_indent(n);
        end
        CH_COLON: begin
          emit_fmt(CH_COLON, n);
          emit_fmt(CH_SPACE, n);
        end
        CH_LF, CH_CR, CH_TAB: begin
          // whitespace outside strings is swallowed, no beats at all
        end
        default: emit_fmt(c, n);
      endcase
    end
    if (n > 0)
      fmt_expected[fmt_expected.size() - 1].run_end = 1'b1;
    if (last_of_doc) begin
      lex_in_string = 1'b0;
      lex_escape    = 1'b0;
      lex_depth     = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_text(input logic [7:0] b, input logic last_of_doc);
    text_queue.push_back('{data: b, doc_end: last_of_doc,
                           gap: send_calm ? 0 : $urandom_range(0, 15)});
  endtask

  // occasional whitespace between tokens, some of it dropped by the block
  task automatic add_blank();
    logic [7:0] ws[4];
    ws = '{CH_LF, CH_CR, CH_TAB, CH_SPACE};
    if ($urandom_range(0, 5) == 0)
      add_text(ws[$urandom_range(0, 3)], 1'b0);
  endtask

  task automatic add_string();
    int unsigned len;
    logic [7:0]  b;
    len = $urandom_range(0, 6);
    add_text(CH_QUOTE, 1'b0);
    for (int i = 0; i < int'(len); i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // escape sequence, the shielded byte may be anything incl. a quote
        add_text(CH_BSLASH, 1'b0);
        add_text(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH)
          b = 8'h78;
        add_text(b, 1'b0);
      end
    end
    add_text(CH_QUOTE, 1'b0);
  endtask

  task automatic add_scalar();
    string words[7];
    string w;
    words = '{"true", "false", "null", "-12.5e+3", "0", "42", "7E-1"};
    w = words[$urandom_range(0, 6)];
    for (int i = 0; i < w.len(); i++)
      add_text(w[i], 1'b0);
  endtask

  task automatic add_value(input int lvl);
    int unsigned pick;
    int unsigned members;
    pick = (lvl == 0) ? $urandom_range(2, 3) : $urandom_range(0, (lvl >= 4) ? 1 : 3);
    case (pick)
      0: add_string();
      1: add_scalar();
      2: begin
        add_text(CH_LBRACE, 1'b0);
        add_blank();
        members = $urandom_range(0, 3);
        for (int k = 0; k < int'(members); k++) begin
          if (k > 0) begin
            add_text(CH_COMMA, 1'b0);
            add_blank();
          end
          add_string();
          add_blank();
          add_text(CH_COLON, 1'b0);
          add_blank();
          add_value(lvl + 1);
        end
        add_blank();
        add_text(CH_RBRACE, 1'b0);
      end
      default: begin
        add_text(CH_LBRACK, 1'b0);
        members = $urandom_range(0, 3);
        for (int k = 0; k < int'(members); k++) begin
          if (k > 0) begin
            add_text(CH_COMMA, 1'b0);
            add_blank();
          end
          add_value(lvl + 1);
        end
        add_text(CH_RBRACK, 1'b0);
      end
    endcase
  endtask

  task automatic build_directed();
    // pass-through extremes and stray closers at depth zero
    add_text(8'h00, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(CH_RBRACE, 1'b0);
    add_text(CH_RBRACK, 1'b0);
    // dropped whitespace, then bare separators at depth zero
    add_text(CH_LF, 1'b0);
    add_text(CH_CR, 1'b0);
    add_text(CH_TAB, 1'b0);
    add_text(CH_COLON, 1'b0);
    add_text(CH_COMMA, 1'b0);
    // nesting, separators inside, then the inner level unwound
    add_text(CH_LBRACE, 1'b0);
    add_text(CH_LBRACK, 1'b0);
    add_text(CH_COMMA, 1'b0);
    add_text(CH_COLON, 1'b0);
    add_text(CH_RBRACK, 1'b0);
    // string with raw whitespace, escaped quote and structural bytes
    add_text(CH_QUOTE, 1'b0);
    add_text(CH_LF, 1'b0);
    add_text(CH_BSLASH, 1'b0);
    add_text(CH_QUOTE, 1'b0);
    add_text(CH_LBRACE, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(CH_QUOTE, 1'b0);
    // document end with depth still open, then mid-string with escape pending
    add_text(CH_LBRACK, 1'b1);
    add_text(CH_QUOTE, 1'b0);
    add_text(CH_BSLASH, 1'b1);
    add_text(CH_RBRACE, 1'b0);
  endtask

  task automatic build_random();
    int unsigned target;
    int unsigned start;
    int unsigned cut;
    int unsigned kind;
    target = text_queue.size() + RANDOM_ITEMS;

    // one deep document walks past the depth ceiling and back
    for (int i = 0; i < DEEP_OPENERS; i++)
      add_text($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK, 1'b0);
    for (int i = 0; i < DEEP_OPENERS; i++)
      add_text($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK, i == DEEP_OPENERS - 1);

    while (text_queue.size() < target) begin
      send_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // raw noise, document end anywhere
        repeat ($urandom_range(1, 8))
          add_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (kind == 1) begin
        // truncated document, ended at an arbitrary byte
        start = text_queue.size();
        add_value(0);
        cut = $urandom_range(start, text_queue.size() - 1);
        while (text_queue.size() > cut + 1)
          void'(text_queue.pop_back());
        text_queue[cut].doc_end = 1'b1;
      end else begin
        add_value(0);
        if ($urandom_range(0, 7) != 0)
          text_queue[text_queue.size() - 1].doc_end = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued text bytes, predicts each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_byte    <= 8'h00;
      in_doc_end <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        format_byte(in_byte, in_doc_end);
      // payload stays put until the current beat is taken
      if (!in_valid || in_ready) begin
        if (text_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (text_queue[0].gap > 0) begin
          text_queue[0].gap = text_queue[0].gap - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_byte    <= text_queue[0].data;
          in_doc_end <= text_queue[0].doc_end;
          text_queue.delete(0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks formatted beats in order, throttles out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : fmt_monitor
    fmt_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fmt_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                   $time, out_byte, out_run_last);
        end else begin
          want = fmt_expected.pop_front();
          if (out_byte !== want.ch) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.ch, out_byte);
          end
          if (out_run_last !== want.run_end) begin
            errors++;
            $display("%0t: out_run_last mismatch, expected %0b, actual %0b",
                     $time, want.run_end, out_run_last);
          end
        end
        beats_seen++;
        if (beats_seen % 40 == 0)
          recv_calm = ($urandom_range(0, 2) == 0);
        // two long holds so the block backs up and stalls its input
        if (beats_seen == 150 || beats_seen == 2000)
          stall_left = LONG_HOLD;
        else
          stall_left = recv_calm ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog: any handshake on either side resets the count
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so the driver's updates have settled
    while (text_queue.size() != 0 || in_valid || fmt_expected.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (fmt_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d formatted beats never arrived", $time, fmt_expected.size());
    end
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/jpp_pkg.sv
hw/rtl/jpp_decode.sv
hw/rtl/jpp_seq.sv
hw/rtl/json_pretty_printer.sv
test/tb.sv
